[rtl/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared codes, default sizes and types of the slot key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int DefSlots      = 16;
    localparam int DefValueBytes = 20;

    localparam logic [7:0] EMPTY_KEY = 8'hFF;

    typedef enum logic [2:0] {
        REQ_GET   = 3'd0,
        REQ_SET   = 3'd1,
        REQ_ERASE = 3'd2,
        REQ_COUNT = 3'd3,
        REQ_CLEAR = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_TOO_SMALL  = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    // Outcome of one pass over the key store.
    typedef struct packed {
        logic done;
        logic found;
        logic empty_found;
    } scan_t;

endpackage

[rtl/slot_key_value_table.sv]
// ----------------------------------------------------------------------------
// slot_key_value_table
// Fixed table of key/value slots with get, set, erase, count and clear all.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                          | Direction
//  --------+------------------------------------------------+----------
//  request | s_valid s_ready s_req_type s_key s_length      | in
//          | s_data_byte s_last                             |
//  result  | m_valid m_ready m_status m_value_length        | out
//          | m_data_byte_out m_entry_count m_last_out       |
//
// A set item that is not the last is only staged. Count, clear all and
// unknown requests go straight to the result step. Get, erase and the
// last item of a set search the key memory one slot per cycle; a get then
// streams its value byte by byte (memory read, then the output register),
// and a set copies the staged bytes into the value memory, VALUE_BYTES
// bytes, each read from staging and then written. Reset clears the
// occupancy bits directly, so there is no clearing pass. A stalled result
// holds the block in its current step; one finished result may wait in the
// output register while the block goes back to accept the next item.
// ----------------------------------------------------------------------------
module slot_key_value_table #(
    parameter int SLOTS       = skvt_pkg::DefSlots,
    parameter int VALUE_BYTES = skvt_pkg::DefValueBytes
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_key,
    input  logic [7:0] s_length,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [4:0] m_value_length,
    output logic [7:0] m_data_byte_out,
    output logic [4:0] m_entry_count,
    output logic       m_last_out
);
    import skvt_pkg::*;

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW  = $clog2(VALUE_BYTES + 1);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int BW  = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam int VD  = SLOTS * VALUE_BYTES;
    localparam int AW  = (VD > 1) ? $clog2(VD) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_GET_RD, S_GET_OUT, S_COPY_RD, S_COPY_WR, S_EMIT
    } state_t;

    state_t         state_reg;
    logic [2:0]     req_reg;
    logic [7:0]     key_reg, len_reg;
    logic [LW-1:0]  stg_count_reg, got_reg;
    logic [BW-1:0]  byte_idx_reg;
    logic [AW-1:0]  base_reg;
    status_t        pend_status_reg;
    logic [4:0]     pend_vlen_reg, pend_count_reg;

    logic           m_valid_reg, m_last_reg;
    logic [2:0]     m_status_reg;
    logic [4:0]     m_vlen_reg, m_count_reg;
    logic [7:0]     m_data_reg;

    // Value and staging memories.
    logic [7:0]     values [VD];
    logic [7:0]     staging [VALUE_BYTES];
    logic [7:0]     val_rdata_reg, stg_rdata_reg;

    logic           accept, out_free, out_load, stg_fits;
    logic [LW-1:0]  stg_count_inc;
    logic [AW-1:0]  val_addr;

    // Key store interface.
    scan_t          scan_st;
    logic           scan_start, wr_en, erase_en, clear_en;
    logic [IW-1:0]  match_idx, empty_idx, wr_idx;
    logic [LW-1:0]  match_len;
    logic [CW-1:0]  entry_count;

    skvt_key_store #(
        .SLOTS       (SLOTS),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_keys (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .scan_start  (scan_start),
        .scan_key    (key_reg),
        .scan_st     (scan_st),
        .match_idx   (match_idx),
        .match_len   (match_len),
        .empty_idx   (empty_idx),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_key      (key_reg),
        .wr_len      (len_reg[LW-1:0]),
        .erase_en    (erase_en),
        .erase_idx   (match_idx),
        .clear_en    (clear_en),
        .entry_count (entry_count)
    );

    // The output register is free when empty or being taken this cycle.
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ((state_reg == S_GET_OUT) || (state_reg == S_EMIT)) && out_free;

    // A set byte is kept while the staging count is below both the
    // declared length and the slot size; anything beyond is dropped.
    assign stg_fits = (8'(stg_count_reg) < s_length)
                   && (stg_count_reg < LW'(VALUE_BYTES));
    assign stg_count_inc = stg_fits ? stg_count_reg + 1'b1 : stg_count_reg;
    assign val_addr = base_reg + AW'(byte_idx_reg);

    // Key store commands. The search is started from the idle step with the
    // key still at the input; the search key is taken from the register,
    // which holds it by the time the first slot's data is being compared.
    always_comb begin
        scan_start = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = match_idx;
        erase_en   = 1'b0;
        clear_en   = 1'b0;
        if (state_reg == S_SCAN && scan_st.done) begin
            if (req_reg == REQ_SET && len_reg <= 8'(VALUE_BYTES)) begin
                wr_en  = scan_st.found || scan_st.empty_found;
                wr_idx = scan_st.found ? match_idx : empty_idx;
            end
            if (req_reg == REQ_ERASE) begin
                erase_en = scan_st.found;
            end
        end
        if (accept) begin
            unique case (s_req_type)
                REQ_GET:   scan_start = (s_key != EMPTY_KEY);
                REQ_SET:   scan_start = s_last && (s_length <= 8'(VALUE_BYTES));
                REQ_ERASE: scan_start = 1'b1;
                REQ_CLEAR: clear_en   = 1'b1;
                default:   scan_start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_req_type == REQ_SET && stg_fits) begin
            staging[stg_count_reg[BW-1:0]] <= s_data_byte;
        end
        if (state_reg == S_COPY_RD) begin
            stg_rdata_reg <= staging[byte_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_COPY_WR) begin
            values[val_addr] <= (LW'(byte_idx_reg) < got_reg) ? stg_rdata_reg : 8'h00;
        end
        if (state_reg == S_GET_RD) begin
            val_rdata_reg <= values[val_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            stg_count_reg   <= '0;
            m_valid_reg     <= 1'b0;
            req_reg         <= '0;
            key_reg         <= '0;
            len_reg         <= '0;
            got_reg         <= '0;
            byte_idx_reg    <= '0;
            base_reg        <= '0;
            pend_status_reg <= ST_OK;
            pend_vlen_reg   <= '0;
            pend_count_reg  <= '0;
            m_last_reg      <= 1'b0;
            m_status_reg    <= '0;
            m_vlen_reg      <= '0;
            m_count_reg     <= '0;
            m_data_reg      <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg        <= s_req_type;
                        key_reg        <= s_key;
                        len_reg        <= s_length;
                        pend_vlen_reg  <= '0;
                        pend_count_reg <= (s_req_type == REQ_COUNT) ? 5'(entry_count) : '0;
                        stg_count_reg  <= (s_req_type == REQ_SET && !s_last) ?
                                          stg_count_inc : '0;
                        unique case (s_req_type)
                            REQ_GET: begin
                                if (s_key == EMPTY_KEY) begin
                                    pend_status_reg <= ST_NOT_FOUND;
                                    state_reg       <= S_EMIT;
                                end else begin
                                    pend_status_reg <= ST_OK;
                                    state_reg       <= S_SCAN;
                                end
                            end
                            REQ_SET: begin
                                if (!s_last) begin
                                    pend_status_reg <= ST_OK;
                                end else begin
                                    got_reg <= stg_count_inc;
                                    if (s_length > 8'(VALUE_BYTES)) begin
                                        pend_status_reg <= ST_BAD_LENGTH;
                                        state_reg       <= S_EMIT;
                                    end else begin
                                        pend_status_reg <= ST_OK;
                                        state_reg       <= S_SCAN;
                                    end
                                end
                            end
                            REQ_ERASE: begin
                                pend_status_reg <= ST_OK;
                                state_reg       <= S_SCAN;
                            end
                            default: begin
                                pend_status_reg <= ST_OK;
                                state_reg       <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_st.done) begin
                        byte_idx_reg <= '0;
                        if (req_reg == REQ_GET) begin
                            base_reg <= AW'(match_idx) * AW'(VALUE_BYTES);
                            if (!scan_st.found) begin
                                pend_status_reg <= ST_NOT_FOUND;
                                state_reg       <= S_EMIT;
                            end else if (8'(match_len) > len_reg) begin
                                pend_status_reg <= ST_TOO_SMALL;
                                pend_vlen_reg   <= 5'(match_len);
                                state_reg       <= S_EMIT;
                            end else if (match_len != '0) begin
                                state_reg <= S_GET_RD;
                            end else begin
                                state_reg <= S_EMIT;
                            end
                        end else if (req_reg == REQ_SET) begin
                            base_reg <= AW'(wr_idx) * AW'(VALUE_BYTES);
                            if (wr_en) begin
                                state_reg <= S_COPY_RD;
                            end else begin
                                pend_status_reg <= ST_FULL;
                                state_reg       <= S_EMIT;
                            end
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_GET_RD: state_reg <= S_GET_OUT;
                S_GET_OUT: begin
                    if (out_free) begin
                        m_status_reg <= ST_OK;
                        m_vlen_reg   <= 5'(match_len);
                        m_data_reg   <= val_rdata_reg;
                        m_count_reg  <= '0;
                        if (LW'(byte_idx_reg) + 1'b1 == match_len) begin
                            m_last_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end else begin
                            m_last_reg   <= 1'b0;
                            byte_idx_reg <= byte_idx_reg + 1'b1;
                            state_reg    <= S_GET_RD;
                        end
                    end
                end
                S_COPY_RD: state_reg <= S_COPY_WR;
                S_COPY_WR: begin
                    if (byte_idx_reg == BW'(VALUE_BYTES - 1)) begin
                        state_reg <= S_EMIT;
                    end else begin
                        byte_idx_reg <= byte_idx_reg + 1'b1;
                        state_reg    <= S_COPY_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_status_reg <= pend_status_reg;
                        m_vlen_reg   <= pend_vlen_reg;
                        m_data_reg   <= '0;
                        m_count_reg  <= pend_count_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_value_length  = m_vlen_reg;
    assign m_data_byte_out = m_data_reg;
    assign m_entry_count   = m_count_reg;
    assign m_last_out      = m_last_reg;

    // The search only reports completion while the controller waits for it.
    a_scan_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_st.done |-> (state_reg == S_SCAN))
        else $error("key search finished outside the search step");

    // The occupied-slot count never exceeds the number of slots.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count <= CW'(SLOTS))
        else $error("occupied-slot count out of range");

    // Staged bytes never exceed the slot size.
    a_staging_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_count_reg <= LW'(VALUE_BYTES))
        else $error("staging count beyond slot size");

    // A streamed get never reads past the stored length.
    a_get_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GET_RD) |-> (LW'(byte_idx_reg) < match_len))
        else $error("get stream beyond stored length");

    // A set copy only writes while its slot was claimed.
    a_copy_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY_RD) && $past(state_reg == S_SCAN) |-> $past(wr_en))
        else $error("value copy without a claimed slot");

endmodule

[rtl/skvt_key_store.sv]
// ----------------------------------------------------------------------------
// skvt_key_store
// Key and length memory with occupancy bits, a one-slot-per-cycle search
// for a key and for the first empty slot, and the count of occupied slots.
// ----------------------------------------------------------------------------
module skvt_key_store #(
    parameter int SLOTS       = 16,
    parameter int VALUE_BYTES = 20,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int LW = $clog2(VALUE_BYTES + 1),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            scan_start,
    input  logic [7:0]      scan_key,
    output skvt_pkg::scan_t scan_st,
    output logic [IW-1:0]   match_idx,
    output logic [LW-1:0]   match_len,
    output logic [IW-1:0]   empty_idx,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_idx,
    input  logic [7:0]      wr_key,
    input  logic [LW-1:0]   wr_len,
    input  logic            erase_en,
    input  logic [IW-1:0]   erase_idx,
    input  logic            clear_en,
    output logic [CW-1:0]   entry_count
);
    import skvt_pkg::*;

    logic [8+LW-1:0] mem [SLOTS];
    logic [8+LW-1:0] rd_data_reg;
    logic [SLOTS-1:0] occ_reg;
    logic [CW-1:0]    count_reg;
    logic             busy_reg, cmp_valid_reg, cmp_last_reg, done_reg;
    logic [IW-1:0]    rd_idx_reg, cmp_idx_reg;
    logic             found_reg, empty_found_reg;
    logic [IW-1:0]    match_idx_reg, empty_idx_reg;
    logic [LW-1:0]    match_len_reg;
    logic [7:0]       slot_key;
    logic             cmp_occ;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_key, wr_len};
        end
        if (busy_reg) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // An unoccupied slot reads as the empty mark whatever the memory holds.
    always_comb begin
        cmp_occ  = occ_reg[cmp_idx_reg];
        slot_key = cmp_occ ? rd_data_reg[8+LW-1:LW] : EMPTY_KEY;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg         <= '0;
            count_reg       <= '0;
            busy_reg        <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            cmp_last_reg    <= 1'b0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            rd_idx_reg      <= '0;
            cmp_idx_reg     <= '0;
            match_idx_reg   <= '0;
            empty_idx_reg   <= '0;
            match_len_reg   <= '0;
        end else begin
            cmp_valid_reg <= busy_reg;
            cmp_idx_reg   <= rd_idx_reg;
            cmp_last_reg  <= busy_reg && (rd_idx_reg == IW'(SLOTS - 1));
            done_reg      <= cmp_valid_reg && cmp_last_reg;
            if (scan_start) begin
                busy_reg        <= 1'b1;
                rd_idx_reg      <= '0;
                found_reg       <= 1'b0;
                empty_found_reg <= 1'b0;
            end else if (busy_reg) begin
                if (rd_idx_reg == IW'(SLOTS - 1)) begin
                    busy_reg <= 1'b0;
                end else begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
            if (cmp_valid_reg) begin
                if ((slot_key == scan_key) && !found_reg) begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= cmp_idx_reg;
                    match_len_reg <= rd_data_reg[LW-1:0];
                end
                if (!cmp_occ && !empty_found_reg) begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= cmp_idx_reg;
                end
            end
            if (clear_en) begin
                occ_reg   <= '0;
                count_reg <= '0;
            end else if (wr_en) begin
                occ_reg[wr_idx] <= (wr_key != EMPTY_KEY);
                if (!occ_reg[wr_idx] && (wr_key != EMPTY_KEY)) begin
                    count_reg <= count_reg + 1'b1;
                end else if (occ_reg[wr_idx] && (wr_key == EMPTY_KEY)) begin
                    count_reg <= count_reg - 1'b1;
                end
            end else if (erase_en) begin
                occ_reg[erase_idx] <= 1'b0;
                if (occ_reg[erase_idx]) begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    assign scan_st.done        = done_reg;
    assign scan_st.found       = found_reg;
    assign scan_st.empty_found = empty_found_reg;
    assign match_idx   = match_idx_reg;
    assign match_len   = match_len_reg;
    assign empty_idx   = empty_idx_reg;
    assign entry_count = count_reg;

endmodule

[verif/tb_slot_key_value_table.sv]
// ----------------------------------------------------------------------------
// tb_slot_key_value_table
// Self-checking testbench for the slot key/value table. A short table of
// directed requests covers the extremes, the error codes and the corner cases.
// A run that fills the table then checks the table-full code. Random request
// sequences follow, most of them well-formed sets and gets with random content.
// Every result is checked field by field against an in-bench model of the
// table. Both handshake sides idle at random, and in one stretch the result
// side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_slot_key_value_table;
    import skvt_pkg::*;

    localparam int NSLOT      = 16;
    localparam int NBYTE      = 20;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 200;

    // Request codes 5 to 7 are not defined; the block answers them with ok.
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] vlen;
        logic [7:0] data;
        logic [4:0] count;
        logic       last;
    } answer_t;

    // One row of the directed table. Where typed is set, the single result
    // is written out here rather than taken from the table model.
    typedef struct {
        logic [2:0] req;
        logic [7:0] key;
        logic [7:0] len;
        logic [7:0] data;
        logic       last;
        bit         typed;
        answer_t    ans;
    } row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_req_type;
    logic [7:0] s_key;
    logic [7:0] s_length;
    logic [7:0] s_data_byte;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic [4:0] m_value_length;
    logic [7:0] m_data_byte_out;
    logic [4:0] m_entry_count;
    logic       m_last_out;

    // The table model: keys, lengths and values of every slot, plus the
    // bytes of a set that is still being streamed in.
    logic [7:0] mdl_keys [NSLOT];
    logic [4:0] mdl_lens [NSLOT];
    logic [7:0] mdl_vals [NSLOT][NBYTE];
    logic [7:0] mdl_stage [NBYTE];
    int         mdl_stage_cnt;

    answer_t    pending_answers[$];

    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  hold_off;
    int  fail_cnt;
    int  items_sent;
    int  answers_seen;
    int  full_seen;
    int  bad_len_seen;
    int  too_small_seen;

    slot_key_value_table u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_key           (s_key),
        .s_length        (s_length),
        .s_data_byte     (s_data_byte),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_value_length  (m_value_length),
        .m_data_byte_out (m_data_byte_out),
        .m_entry_count   (m_entry_count),
        .m_last_out      (m_last_out)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic answer_t mk_answer(logic [2:0] st, logic [4:0] vl, logic [7:0] d,
                                          logic [4:0] c);
        answer_t a;
        a.status = st;
        a.vlen   = vl;
        a.data   = d;
        a.count  = c;
        a.last   = 1'b1;
        return a;
    endfunction

    function automatic int find_slot(logic [7:0] k);
        for (int i = 0; i < NSLOT; i++) begin
            if (mdl_keys[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            mdl_keys[i] = EMPTY_KEY;
            mdl_lens[i] = '0;
        end
        mdl_stage_cnt = 0;
    endfunction

    // Applies one accepted item to the table model and queues the results
    // that it causes.
    function automatic void table_apply(logic [2:0] rt, logic [7:0] k, logic [7:0] l,
                                        logic [7:0] d, logic lst);
        int      s;
        int      got;
        answer_t a;
        if (rt != REQ_SET) mdl_stage_cnt = 0;
        case (rt)
            REQ_GET: begin
                s = (k == EMPTY_KEY) ? -1 : find_slot(k);
                if (s < 0) begin
                    pending_answers.push_back(mk_answer(ST_NOT_FOUND, 0, 0, 0));
                end else if (mdl_lens[s] > l) begin
                    too_small_seen++;
                    pending_answers.push_back(mk_answer(ST_TOO_SMALL, mdl_lens[s], 0, 0));
                end else if (mdl_lens[s] == 0) begin
                    pending_answers.push_back(mk_answer(ST_OK, 0, 0, 0));
                end else begin
                    for (int i = 0; i < mdl_lens[s]; i++) begin
                        a = mk_answer(ST_OK, mdl_lens[s], mdl_vals[s][i], 0);
                        a.last = (i + 1 == mdl_lens[s]);
                        pending_answers.push_back(a);
                    end
                end
            end
            REQ_SET: begin
                if (mdl_stage_cnt < l && mdl_stage_cnt < NBYTE) begin
                    mdl_stage[mdl_stage_cnt] = d;
                    mdl_stage_cnt++;
                end
                if (lst) begin
                    got = mdl_stage_cnt;
                    mdl_stage_cnt = 0;
                    if (l > NBYTE) begin
                        bad_len_seen++;
                        pending_answers.push_back(mk_answer(ST_BAD_LENGTH, 0, 0, 0));
                    end else begin
                        s = find_slot(k);
                        if (s < 0) s = find_slot(EMPTY_KEY);
                        if (s < 0) begin
                            full_seen++;
                            pending_answers.push_back(mk_answer(ST_FULL, 0, 0, 0));
                        end else begin
                            mdl_keys[s] = k;
                            mdl_lens[s] = l[4:0];
                            for (int i = 0; i < NBYTE; i++) begin
                                mdl_vals[s][i] = (i < got && i < l) ? mdl_stage[i] : 8'h00;
                            end
                            pending_answers.push_back(mk_answer(ST_OK, 0, 0, 0));
                        end
                    end
                end
            end
            REQ_ERASE: begin
                s = find_slot(k);
                if (s >= 0) begin
                    mdl_keys[s] = EMPTY_KEY;
                    mdl_lens[s] = '0;
                end
                pending_answers.push_back(mk_answer(ST_OK, 0, 0, 0));
            end
            REQ_COUNT: begin
                got = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (mdl_keys[i] != EMPTY_KEY) got++;
                end
                pending_answers.push_back(mk_answer(ST_OK, 0, 0, got[4:0]));
            end
            REQ_CLEAR: begin
                table_reset();
                pending_answers.push_back(mk_answer(ST_OK, 0, 0, 0));
            end
            default: begin
                pending_answers.push_back(mk_answer(ST_OK, 0, 0, 0));
            end
        endcase
    endfunction

    // Offers one item on the request side, idling first at the current rate,
    // and applies it to the table model once the block has taken it.
    task automatic offer_item(logic [2:0] rt, logic [7:0] k, logic [7:0] l,
                              logic [7:0] d, logic lst);
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= rt;
        s_key       <= k;
        s_length    <= l;
        s_data_byte <= d;
        s_last      <= lst;
        do @(posedge aclk); while (!s_ready);
        table_apply(rt, k, l, d, lst);
        items_sent++;
    endtask

    // A complete set: one item per byte, or a single item for an empty value.
    // Now and then the number of streamed bytes does not match the length,
    // so that padding with zeros and dropping of extra bytes both occur.
    task automatic stream_set(logic [7:0] k, logic [7:0] l);
        int n;
        n = (l == 0) ? 1 : l;
        if ($urandom_range(0, 99) < 20) n = $urandom_range(1, n + 2);
        for (int i = 0; i < n; i++) begin
            offer_item(REQ_SET, k, l, $urandom_range(0, 255), i == n - 1);
        end
    endtask

    // The result side: idles at the current rate, and on request holds off
    // for a long stretch so that the block fills up and stops taking items.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                repeat (HOLD_LEN) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Every result taken is compared with the oldest one still awaited.
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: status %0d last %0d", m_status, m_last_out);
                fail_cnt++;
            end else begin
                want = pending_answers.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_cnt++;
                end
                if (m_value_length !== want.vlen) begin
                    $error("value_length: expected %0d, got %0d", want.vlen, m_value_length);
                    fail_cnt++;
                end
                if (m_data_byte_out !== want.data) begin
                    $error("data_byte_out: expected %0h, got %0h", want.data,
                           m_data_byte_out);
                    fail_cnt++;
                end
                if (m_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_entry_count);
                    fail_cnt++;
                end
                if (m_last_out !== want.last) begin
                    $error("last_out: expected %0d, got %0d", want.last, m_last_out);
                    fail_cnt++;
                end
            end
        end
    end

    // A hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("tb_slot_key_value_table failed");
        $finish;
    end

    // The key pool is small so that sets, gets and erases meet each other
    // often; between them its members still toggle every key bit.
    logic [7:0] key_pool [12] = '{8'h00, 8'h01, 8'h12, 8'h24, 8'h48, 8'h90,
                                  8'hFE, 8'h7F, 8'h3C, 8'hC3, 8'hA5, 8'h5A};

    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 99) < 10) return $urandom_range(0, 255);
        return key_pool[$urandom_range(0, 11)];
    endfunction

    task automatic random_phase(int n_items);
        int         r;
        int         stop_at;
        logic [7:0] l;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                l = ($urandom_range(0, 9) == 0) ? $urandom_range(7, NBYTE)
                                                : $urandom_range(0, 6);
                stream_set(pick_key(), l);
            end else if (r < 65) begin
                l = ($urandom_range(0, 9) < 7) ? $urandom_range(NBYTE, 255)
                                               : $urandom_range(0, 255);
                offer_item(REQ_GET, pick_key(), l, $urandom_range(0, 255),
                           $urandom_range(0, 1));
            end else if (r < 75) begin
                offer_item(REQ_ERASE, pick_key(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
            end else if (r < 85) begin
                offer_item(REQ_COUNT, pick_key(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
            end else if (r < 88) begin
                offer_item(REQ_CLEAR, pick_key(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
            end else if (r < 91) begin
                offer_item($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI), pick_key(),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 1));
            end else if (r < 96) begin
                // A set broken off part way; a later set item adds to its staged bytes, other requests drop them.
                l = $urandom_range(1, NBYTE);
                repeat ($urandom_range(1, 3)) begin
                    offer_item(REQ_SET, pick_key(), l, $urandom_range(0, 255), 1'b0);
                end
            end else begin
                l = $urandom_range(NBYTE + 1, 255);
                repeat ($urandom_range(1, 2) - 1) begin
                    offer_item(REQ_SET, pick_key(), l, $urandom_range(0, 255), 1'b0);
                end
                offer_item(REQ_SET, pick_key(), l, $urandom_range(0, 255), 1'b1);
            end
        end
    endtask

    // Directed requests. Rows with a typed answer carry a single known
    // result; the others are checked against the table model.
    row_t steps[] = '{
        '{REQ_COUNT, 8'h00, 8'h00, 8'h00, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_GET,   8'h05, 8'hFF, 8'h00, 1'b1, 1, '{ST_NOT_FOUND, 0, 0, 0, 1}},
        '{REQ_GET,   8'hFF, 8'hFF, 8'hFF, 1'b0, 1, '{ST_NOT_FOUND, 0, 0, 0, 1}},
        '{REQ_ERASE, 8'h09, 8'h00, 8'h00, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_SET,   8'h00, 8'd21, 8'h00, 1'b1, 1, '{ST_BAD_LENGTH, 0, 0, 0, 1}},
        '{REQ_SET,   8'h01, 8'hFF, 8'hFF, 1'b1, 1, '{ST_BAD_LENGTH, 0, 0, 0, 1}},
        '{REQ_SET,   8'h10, 8'h00, 8'h77, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_GET,   8'h10, 8'h00, 8'h00, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_SET,   8'h20, 8'h02, 8'hAA, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{REQ_SET,   8'h20, 8'h02, 8'h55, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_GET,   8'h20, 8'h01, 8'h00, 1'b1, 1, '{ST_TOO_SMALL, 2, 0, 0, 1}},
        '{REQ_GET,   8'h20, 8'hFF, 8'h00, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{REQ_SET,   8'hFF, 8'h00, 8'h00, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_SPARE_LO, 8'h20, 8'h00, 8'h00, 1'b0, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_COUNT, 8'h00, 8'h00, 8'h00, 1'b1, 1, '{ST_OK, 0, 0, 2, 1}},
        '{REQ_SET,   8'h30, 8'h03, 8'h11, 1'b0, 0, '{0, 0, 0, 0, 0}},
        '{REQ_GET,   8'h30, 8'hFF, 8'h00, 1'b1, 1, '{ST_NOT_FOUND, 0, 0, 0, 1}},
        '{REQ_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1, 1, '{ST_OK, 0, 0, 0, 1}},
        '{REQ_COUNT, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1, '{ST_OK, 0, 0, 0, 1}}
    };

    initial begin
        s_valid      = 1'b0;
        s_req_type   = REQ_COUNT;
        s_key        = '0;
        s_length     = '0;
        s_data_byte  = '0;
        s_last       = 1'b0;
        aresetn      = 1'b0;
        hold_off     = 1'b0;
        fail_cnt     = 0;
        items_sent   = 0;
        answers_seen = 0;
        full_seen    = 0;
        bad_len_seen = 0;
        too_small_seen = 0;
        snd_idle_pct = 27;
        rcv_idle_pct = 85;
        table_reset();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (steps[i]) begin
            offer_item(steps[i].req, steps[i].key, steps[i].len, steps[i].data,
                       steps[i].last);
            if (steps[i].typed) pending_answers[$] = steps[i].ans;
        end

        // Fill all sixteen slots with empty values; the next new key must
        // find the table full. A longest-value set and get come after.
        for (int i = 0; i < NSLOT; i++) begin
            offer_item(REQ_SET, 8'h40 + i, 8'h00, 8'h00, 1'b1);
        end
        offer_item(REQ_SET, 8'hEE, 8'h00, 8'h00, 1'b1);
        pending_answers[$] = mk_answer(ST_FULL, 0, 0, 0);
        stream_set(8'h40, NBYTE);
        offer_item(REQ_GET, 8'h40, NBYTE, 8'h00, 1'b1);
        offer_item(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 1'b1);

        random_phase(40);
        snd_idle_pct = 85;
        rcv_idle_pct = 27;
        random_phase(40);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_off = 1'b1;
        random_phase(40);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d request items and checked %0d results.", items_sent,
                 answers_seen);
        $display("Seen: %0d table full, %0d bad length, %0d buffer too small.",
                 full_seen, bad_len_seen, too_small_seen);
        if (fail_cnt == 0) begin
            $display("tb_slot_key_value_table passed");
        end else begin
            $display("tb_slot_key_value_table failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/skvt_pkg.sv
rtl/skvt_key_store.sv
rtl/slot_key_value_table.sv
verif/tb_slot_key_value_table.sv
